### design/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types, constants and calendar tables for the day counting unit.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int CountW  = 23;
  localparam int SerialW = 23;
  localparam int ProdW   = 27;
  localparam int QuotW   = 8;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for x below 43690
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int          Recip100Shift = 19;

  localparam logic [MonthW-1:0] MonthFirst = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthLast  = 4'd12;

  localparam logic [CountW-1:0] CountSat  = 23'h3FFFFF;
  localparam logic [CountW-1:0] CountPast = '1;
  localparam logic [CountW-1:0] CountOne  = 23'd1;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic sum;
    logic sel;
    logic finish;
  } dbd_cmd_t;

  typedef struct packed {
    logic out_free;
  } dbd_status_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    r = 5'd31;
    unique case (m)
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    r = 9'd0;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### design/dbd_req_if.sv
// ----------------------------------------------------------------------------
// dbd_req_if
// Request channel: a pair of dates and a counting mode.
// ----------------------------------------------------------------------------
interface dbd_req_if
  import dbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [YearW-1:0]  from_year;
  logic [MonthW-1:0] from_month;
  logic [DayW-1:0]   from_day;
  logic [YearW-1:0]  to_year;
  logic [MonthW-1:0] to_month;
  logic [DayW-1:0]   to_day;

  modport source (output valid, mode, from_year, from_month, from_day,
                  to_year, to_month, to_day, input ready);
  modport sink   (input valid, mode, from_year, from_month, from_day,
                  to_year, to_month, to_day, output ready);
endinterface

### design/dbd_rsp_if.sv
// ----------------------------------------------------------------------------
// dbd_rsp_if
// Response channel: the day count and the past flag.
// ----------------------------------------------------------------------------
interface dbd_rsp_if
  import dbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count;
  logic              already_past;

  modport source (output valid, day_count, already_past, input ready);
  modport sink   (input valid, day_count, already_past, output ready);
endinterface

### design/dbd_ctrl.sv
// ----------------------------------------------------------------------------
// dbd_ctrl
// Sequencer: runs each date of an item through the serial day datapath,
// then hands the difference to the output register.
// ----------------------------------------------------------------------------
module dbd_ctrl
  import dbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  dbd_status_t status,
  output dbd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SUM,
    S_DONE
  } state_t;

  state_t state;
  logic   sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      req_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= S_PREP;
            sel       <= 1'b0;
            req_ready <= 1'b0;
          end
        end
        S_PREP: state <= S_SUM;
        S_SUM: begin
          if (sel) begin
            state <= S_DONE;
          end else begin
            sel   <= 1'b1;
            state <= S_PREP;
          end
        end
        S_DONE: begin
          if (status.out_free) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = sel;
    cmd.load   = (state == S_IDLE) && req_valid && req_ready;
    cmd.prep   = (state == S_PREP);
    cmd.sum    = (state == S_SUM);
    cmd.finish = (state == S_DONE) && status.out_free;
  end

endmodule

### design/dbd_datapath.sv
// ----------------------------------------------------------------------------
// dbd_datapath
// Date clamping, serial day number in two stages, difference and
// output register.
// ----------------------------------------------------------------------------
module dbd_datapath
  import dbd_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  dbd_cmd_t    cmd,
  output dbd_status_t status,
  dbd_req_if.sink     req,
  dbd_rsp_if.source   rsp
);

  localparam logic [16:0]      MaxYearW = 17'(MAX_YEAR);
  localparam logic [YearW-1:0] MaxYearT = YearW'(MAX_YEAR);

  logic              mode_r;
  date_t             date_a;
  date_t             date_b;
  logic [SerialW-1:0] serial_a;
  logic [SerialW-1:0] serial_b;

  // stage one registers
  logic [YearW-1:0]   y_q;
  logic [YearW-1:0]   p_q;
  logic [MonthW-1:0]  m_q;
  logic [DayW-1:0]    d_q;
  logic [ProdW-1:0]   prod_y;
  logic [ProdW-1:0]   prod_p;
  logic [SerialW-1:0] p365;

  // output register
  logic              out_valid;
  logic [CountW-1:0] out_count;
  logic              out_past;

  date_t             cur;
  logic [YearW-1:0]  y_c;
  logic [YearW-1:0]  p_c;
  logic [MonthW-1:0] m_c;

  logic [QuotW-1:0]   q_y;
  logic [QuotW-1:0]   q_p;
  logic               leap;
  logic [DayW-1:0]    dim;
  logic [DayW-1:0]    d_c;
  logic [SerialW-1:0] serial_n;

  logic [SerialW:0]  diff;
  logic [CountW-1:0] count_n;
  logic              past_n;

  // select and clamp the current date
  always_comb begin
    cur = cmd.sel ? date_b : date_a;
    if (cur.year == '0) begin
      y_c = YearW'(1);
    end else if ({3'b000, cur.year} > MaxYearW) begin
      y_c = MaxYearT;
    end else begin
      y_c = cur.year;
    end
    p_c = y_c - YearW'(1);
    if (cur.month == '0) begin
      m_c = MonthFirst;
    end else if (cur.month > MonthLast) begin
      m_c = MonthLast;
    end else begin
      m_c = cur.month;
    end
  end

  // leap rule from quotients of y and y - 1 by 100, day clamp and serial day number
  always_comb begin
    q_y  = prod_y[Recip100Shift +: QuotW];
    q_p  = prod_p[Recip100Shift +: QuotW];
    leap = ((y_q[1:0] == 2'b00) && (q_y == q_p)) || (q_y[QuotW-1:2] != q_p[QuotW-1:2]);
    dim  = month_days(m_q, leap);
    if (d_q == '0) begin
      d_c = DayW'(1);
    end else if (d_q > dim) begin
      d_c = dim;
    end else begin
      d_c = d_q;
    end
    serial_n = p365
             + SerialW'(p_q[YearW-1:2])
             - SerialW'(q_p)
             + SerialW'(q_p[QuotW-1:2])
             + SerialW'(days_before(m_q))
             + SerialW'((m_q > MonthFeb) && leap)
             + SerialW'(d_c);
  end

  // difference and saturation
  always_comb begin
    count_n = CountOne;
    past_n  = 1'b0;
    diff    = {1'b0, serial_b} - {1'b0, serial_a};
    if (!mode_r) begin
      if (serial_a < serial_b) begin
        diff = diff + (SerialW+1)'(1);
        count_n = (diff > (SerialW+1)'(CountSat)) ? CountSat : CountW'(diff);
      end
    end else if (serial_a > serial_b) begin
      count_n = CountPast;
      past_n  = 1'b1;
    end else begin
      count_n = (diff > (SerialW+1)'(CountSat)) ? CountSat : CountW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= req.mode;
      date_a <= '{year: req.from_year, month: req.from_month, day: req.from_day};
      date_b <= '{year: req.to_year, month: req.to_month, day: req.to_day};
    end
    if (cmd.prep) begin
      y_q    <= y_c;
      p_q    <= p_c;
      m_q    <= m_c;
      d_q    <= cur.day;
      prod_y <= ProdW'(y_c) * ProdW'(Recip100);
      prod_p <= ProdW'(p_c) * ProdW'(Recip100);
      p365   <= SerialW'(p_c) * SerialW'(365);
    end
    if (cmd.sum) begin
      if (cmd.sel) begin
        serial_b <= serial_n;
      end else begin
        serial_a <= serial_n;
      end
    end
    if (cmd.finish) begin
      out_count <= count_n;
      out_past  <= past_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free  = !out_valid || rsp.ready;
  assign rsp.valid        = out_valid;
  assign rsp.day_count    = out_count;
  assign rsp.already_past = out_past;

endmodule

### design/days_between_dates_unit.sv
// ----------------------------------------------------------------------------
// days_between_dates_unit
// A new item is accepted only once the sequencer is back in S_IDLE;
// each date goes through a clamp/multiply step (S_PREP) and a summing
// step (S_SUM) in one shared serial day datapath.
// The output register frees the input side while a result waits.
// Reset clears the sequencer and the output valid flag only.
// ----------------------------------------------------------------------------
module days_between_dates_unit
  import dbd_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic      clk,
  input  logic      rst,
  dbd_req_if.sink   req,
  dbd_rsp_if.source rsp
);

  dbd_cmd_t    cmd;
  dbd_status_t status;

  dbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dbd_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .req    (req),
    .rsp    (rsp)
  );

  a_past_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.already_past |-> rsp.day_count == CountPast)
    else $error("past flag without minus one count");

  a_count_sign: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.already_past |-> !rsp.day_count[CountW-1])
    else $error("negative count without past flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input still ready after an accepted item");

  a_finish_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded over a pending one");

endmodule

### tb/days_between_dates_unit_tb.sv
// ----------------------------------------------------------------------------
// days_between_dates_unit_tb
// Drives date pairs into the day counting unit under random source gaps and
// sink stalls, predicts each count and past flag from its own calendar
// arithmetic, and checks every result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module days_between_dates_unit_tb;
  import dbd_pkg::*;

  localparam int YearMax = 9999;

  localparam logic ModeInclusive = 1'b0;
  localparam logic ModeRemaining = 1'b1;

  typedef struct {
    logic  mode;
    date_t from_d;
    date_t to_d;
  } date_pair_t;

  typedef struct {
    logic [CountW-1:0] count;
    logic              past;
  } span_result_t;

  logic clk;
  logic rst;

  dbd_req_if req_ch ();
  dbd_rsp_if rsp_ch ();

  days_between_dates_unit #(.MAX_YEAR(YearMax)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  span_result_t pending_spans[$];
  int           error_count;
  int           items_sent;
  int           remaining_items;
  int           past_items;
  int           results_seen;
  bit           idle_on;
  bit           stall_on;

  always #1 clk = ~clk;

  function automatic bit leap_year(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(input int m, input int y);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int days_ahead_of(input int m);
    int total;
    total = 0;
    for (int k = 1; k < m; k++) total += month_length(k, 1);
    return total;
  endfunction

  // day number of a date after clamping its fields, 1 for 0001-01-01
  function automatic int day_ordinal(input date_t d);
    int y;
    int m;
    int dd;
    int p;
    int n;
    y  = int'(d.year);
    m  = int'(d.month);
    dd = int'(d.day);
    if (y < 1) y = 1;
    if (y > YearMax) y = YearMax;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (dd < 1) dd = 1;
    if (dd > month_length(m, y)) dd = month_length(m, y);
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400 + days_ahead_of(m) + dd;
    if (m > 2 && leap_year(y)) n += 1;
    return n;
  endfunction

  function automatic span_result_t predict_span(input date_pair_t p);
    span_result_t r;
    int a;
    int b;
    int n;
    a = day_ordinal(p.from_d);
    b = day_ordinal(p.to_d);
    r.past = 1'b0;
    if (p.mode == ModeInclusive) begin
      n = (a < b) ? b - a + 1 : 1;
    end else if (a > b) begin
      n = -1;
      r.past = 1'b1;
    end else begin
      n = b - a;
    end
    if (n > int'(CountSat)) n = int'(CountSat);
    r.count = CountW'(n);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_year();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 9))
        0:       return 1;
        1:       return 4;
        2:       return 100;
        3:       return 400;
        4:       return 1900;
        5:       return 2000;
        6:       return 2024;
        7:       return 2100;
        8:       return 9996;
        default: return YearMax;
      endcase
    end
    return $urandom_range(1, YearMax);
  endfunction

  function automatic date_t legal_date(input int y);
    date_t d;
    int m;
    m = $urandom_range(1, 12);
    d.year  = YearW'(y);
    d.month = MonthW'(m);
    d.day   = DayW'($urandom_range(1, month_length(m, y)));
    return d;
  endfunction

  function automatic date_t raw_date();
    date_t d;
    d.year  = YearW'($urandom);
    d.month = MonthW'($urandom);
    d.day   = DayW'($urandom);
    return d;
  endfunction

  function automatic date_pair_t make_pair(input logic mode,
                                           input int fy, input int fm, input int fd,
                                           input int ty, input int tm, input int td);
    date_pair_t p;
    p.mode         = mode;
    p.from_d.year  = YearW'(fy);
    p.from_d.month = MonthW'(fm);
    p.from_d.day   = DayW'(fd);
    p.to_d.year    = YearW'(ty);
    p.to_d.month   = MonthW'(tm);
    p.to_d.day     = DayW'(td);
    return p;
  endfunction

  function automatic date_pair_t random_pair(input bit raw);
    date_pair_t p;
    int r;
    int y;
    p.mode = $urandom_range(0, 1) ? ModeRemaining : ModeInclusive;
    if (raw) begin
      p.from_d = raw_date();
      p.to_d   = raw_date();
      return p;
    end
    p.from_d = legal_date(pick_year());
    r = $urandom_range(0, 9);
    if (r == 0) begin
      p.to_d = p.from_d;
    end else if (r < 5) begin
      y = int'(p.from_d.year) + $urandom_range(0, 2) - 1;
      if (y < 1) y = 1;
      if (y > YearMax) y = YearMax;
      p.to_d = legal_date(y);
    end else begin
      p.to_d = legal_date(pick_year());
    end
    return p;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // entered and left at a falling edge
  task automatic send_pair(input date_pair_t p);
    int gap;
    span_result_t want;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.mode       = p.mode;
    req_ch.from_year  = p.from_d.year;
    req_ch.from_month = p.from_d.month;
    req_ch.from_day   = p.from_d.day;
    req_ch.to_year    = p.to_d.year;
    req_ch.to_month   = p.to_d.month;
    req_ch.to_day     = p.to_d.day;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_span(p);
    pending_spans.push_back(want);
    items_sent++;
    if (p.mode == ModeRemaining) remaining_items++;
    if (want.past) past_items++;
    @(negedge clk);
  endtask

  task automatic check_result();
    span_result_t want;
    if (pending_spans.size() == 0) begin
      report_error($sformatf("result with no item pending: count %0d past %0b",
                             $signed(rsp_ch.day_count), rsp_ch.already_past));
      return;
    end
    want = pending_spans.pop_front();
    results_seen++;
    if (rsp_ch.day_count !== want.count)
      report_error($sformatf("day_count got %0d expected %0d",
                             $signed(rsp_ch.day_count), $signed(want.count)));
    if (rsp_ch.already_past !== want.past)
      report_error($sformatf("already_past got %0b expected %0b",
                             rsp_ch.already_past, want.past));
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) check_result();
  end

  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        hold--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (stall_on) hold = pick_gap();
      end
    end
  end

  task automatic test_directed();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_pair(make_pair(ModeInclusive, 2024, 3, 15, 2024, 3, 15));
    send_pair(make_pair(ModeRemaining, 2024, 3, 15, 2024, 3, 15));
    send_pair(make_pair(ModeInclusive, 2024, 3, 16, 2024, 3, 15));
    send_pair(make_pair(ModeRemaining, 2024, 3, 16, 2024, 3, 15));
    send_pair(make_pair(ModeInclusive, 1, 1, 1, YearMax, 12, 31));
    send_pair(make_pair(ModeRemaining, 1, 1, 1, YearMax, 12, 31));
    send_pair(make_pair(ModeRemaining, YearMax, 12, 31, 1, 1, 1));
    send_pair(make_pair(ModeRemaining, 0, 1, 1, 1, 1, 1));
    send_pair(make_pair(ModeInclusive, 0, 0, 0, 16383, 15, 31));
    send_pair(make_pair(ModeRemaining, 16383, 15, 31, YearMax, 12, 31));
    send_pair(make_pair(ModeRemaining, 10000, 1, 1, YearMax, 1, 1));
    send_pair(make_pair(ModeInclusive, 2020, 0, 10, 2020, 13, 10));
    send_pair(make_pair(ModeRemaining, 2020, 1, 0, 2020, 4, 31));
    send_pair(make_pair(ModeInclusive, 2000, 2, 30, 2000, 3, 1));
    send_pair(make_pair(ModeRemaining, 1900, 2, 29, 1900, 3, 1));
    send_pair(make_pair(ModeInclusive, 2024, 2, 29, 2023, 2, 29));
    send_pair(make_pair(ModeRemaining, 2023, 2, 29, 2024, 2, 29));
    send_pair(make_pair(ModeInclusive, 2000, 2, 28, 2000, 3, 1));
    send_pair(make_pair(ModeRemaining, 2100, 2, 28, 2100, 3, 1));
    send_pair(make_pair(ModeInclusive, 1999, 12, 31, 2000, 1, 1));
    send_pair(make_pair(ModeRemaining, 400, 12, 31, 401, 1, 1));
    send_pair(make_pair(ModeInclusive, 2021, 6, 31, 2021, 7, 1));
    send_pair(make_pair(ModeRemaining, 2021, 15, 0, 2021, 12, 30));
    send_pair(make_pair(ModeInclusive, 9998, 11, 30, 0, 15, 31));
  endtask

  task automatic test_legal_dates(input int n);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < n; i++) send_pair(random_pair(1'b0));
  endtask

  task automatic test_raw_fields(input int n);
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < n; i++) send_pair(random_pair(1'b1));
  endtask

  task automatic test_back_to_back(input int n);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    for (int i = 0; i < n; i++) send_pair(random_pair($urandom_range(0, 3) == 0));
  endtask

  task automatic test_sink_stall(input int n);
    idle_on  = 1'b0;
    stall_on = 1'b1;
    for (int i = 0; i < n; i++) send_pair(random_pair($urandom_range(0, 3) == 0));
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    idle_on           = 1'b0;
    stall_on          = 1'b0;
    error_count       = 0;
    items_sent        = 0;
    remaining_items   = 0;
    past_items        = 0;
    results_seen      = 0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = ModeInclusive;
    req_ch.from_year  = '0;
    req_ch.from_month = '0;
    req_ch.from_day   = '0;
    req_ch.to_year    = '0;
    req_ch.to_month   = '0;
    req_ch.to_day     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_legal_dates(450);
    test_raw_fields(200);
    test_back_to_back(150);
    test_sink_stall(100);

    req_ch.valid = 1'b0;
    stall_on     = 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("sent %0d date pairs (%0d days remaining, %0d already past), %0d results",
             items_sent, remaining_items, past_items, results_seen);
    $display("with source gaps, sink stalls, clamped fields and back-to-back runs");
    if (error_count == 0) begin
      $display("PASS days_between_dates_unit");
    end else begin
      $display("FAIL days_between_dates_unit");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results still pending", pending_spans.size());
    $display("FAIL days_between_dates_unit");
    $finish;
  end

endmodule

### days_between_dates_unit.f
design/dbd_pkg.sv
design/dbd_req_if.sv
design/dbd_rsp_if.sv
design/dbd_ctrl.sv
design/dbd_datapath.sv
design/days_between_dates_unit.sv
tb/days_between_dates_unit_tb.sv
